/* sv/sbl_pkg.sv */
package sbl_pkg;

  // channel and register widths fixed by the stream format
  localparam int CHAN_W = 8;
  localparam int SUM_W  = CHAN_W + 2;
  localparam int SIZE_W = 11;
  localparam int PIX_W  = 3 * CHAN_W;

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  // one RGB sample, red in the low bits
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // line store word: row above and current row at one column
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_DIRECTION = 2'd2
  } reg_idx_t;

  // window control decided at accept time
  typedef struct packed {
    logic emit;       // request produces a result
    logic left_mid;   // left column taken from the newer stored column
    logic right_new;  // right column is the incoming column
    logic top_mid;    // top row replicated from the middle row
    logic bot_mid;    // bottom row replicated from the middle row
    logic last;       // final result of the frame
  } win_ctl_t;

endpackage

/* sv/sobel_rgb_gradient_filter.sv */
// RGB Sobel gradient filter. Pixels enter in raster order, one request per
// clock while s_tready is high (s_tuser low); each channel gets the 3x3
// horizontal or vertical Sobel derivative (register 2), absolute value
// saturated to 255, with edge samples replicated. The result for a pixel
// leaves one row and one pixel after it went in, so after the last pixel of
// a frame send width+1 flush requests (s_tuser high) to drain; m_tlast marks
// the frame's final result. Flushes before the frame is complete are dropped.
// A request passes the command queue, the stage-one register and the output
// register before m_tvalid; a queue of QUEUE_DEPTH requests lets input keep
// flowing while the output is stalled. Two line stores share one memory word
// per column, read when a request leaves the queue and written back when it
// moves on to the output register. Writing width or height restarts the frame.
module sobel_rgb_gradient_filter #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sbl_pkg::PIX_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  input  logic                         s_tuser,   // operation
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sbl_pkg::PIX_W-1:0]    m_tdata,   // red_out, green_out, blue_out
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [sbl_pkg::SIZE_W-1:0]   cfg_data
);
  import sbl_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(win_ctl_t) + $bits(pixel_t);

  logic          cmd_push;
  logic [CW-1:0] cmd_col;
  win_ctl_t      cmd_ctl;
  pixel_t        cmd_pix;
  logic          direction;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_out;
  logic [CW-1:0] q_col;
  win_ctl_t      q_ctl;
  pixel_t        q_pix;
  pixel_t        out_pix;

  sbl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd_col   (cmd_col),
    .cmd_ctl   (cmd_ctl),
    .cmd_pix   (cmd_pix),
    .direction (direction)
  );

  sbl_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data ({cmd_col, cmd_ctl, cmd_pix}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  assign {q_col, q_ctl, q_pix} = q_out;

  sbl_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_col     (q_col),
    .q_ctl     (q_ctl),
    .q_pix     (q_pix),
    .direction (direction),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (out_pix),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = out_pix;

endmodule

/* sv/sbl_front.sv */
module sbl_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [sbl_pkg::PIX_W-1:0]              s_tdata,
  input  logic                                   s_tuser,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [sbl_pkg::SIZE_W-1:0]             cfg_data,
  // command queue side
  input  logic                                   q_full,
  output logic                                   cmd_push,
  output logic [$clog2(MAX_WIDTH)-1:0]           cmd_col,
  output sbl_pkg::win_ctl_t                      cmd_ctl,
  output sbl_pkg::pixel_t                        cmd_pix,
  output logic                                   direction
);
  import sbl_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int XW  = ((MW > SIZE_W) ? MW : SIZE_W) + 1;

  logic [SIZE_W-1:0] img_w;
  logic [SIZE_W-1:0] img_h;
  logic [CW-1:0]     in_col;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     out_col;
  logic [ORW-1:0]    out_row;

  logic [CW-1:0]     in_col_next;
  logic [RW-1:0]     in_row_next;
  logic [CW-1:0]     out_col_next;
  logic [ORW-1:0]    out_row_next;

  logic              cfg_we;
  logic              size_we;
  logic [SIZE_W-1:0] size_w_val;
  logic [SIZE_W-1:0] size_h_val;
  logic              pixel_phase;
  logic              ignore;
  logic              emit;
  logic              col_wrap;
  logic              out_col_end;
  logic              out_row_end;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign size_we   = cfg_we && (reg_idx_t'(cfg_index) == REG_WIDTH ||
                                reg_idx_t'(cfg_index) == REG_HEIGHT);

  // saturate written sizes into the legal range
  always_comb begin
    if (cfg_data < MIN_SIZE) begin
      size_w_val = MIN_SIZE;
      size_h_val = MIN_SIZE;
    end else begin
      size_w_val = (32'(cfg_data) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : cfg_data;
      size_h_val = (32'(cfg_data) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : cfg_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w     <= WIDTH_RESET;
      img_h     <= HEIGHT_RESET;
      direction <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:     img_w     <= size_w_val;
        REG_HEIGHT:    img_h     <= size_h_val;
        REG_DIRECTION: direction <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // classify the request against the frame position
  assign pixel_phase = XW'(in_row) < XW'(img_h);
  assign ignore      = (op_t'(s_tuser) == OP_FLUSH) && pixel_phase;
  assign emit        = (in_row > RW'(1)) || (in_row == RW'(1) && in_col != '0);
  assign col_wrap    = (XW'(in_col) + XW'(1)) >= XW'(img_w);
  assign out_col_end = (XW'(out_col) + XW'(1)) >= XW'(img_w);
  assign out_row_end = (XW'(out_row) + XW'(1)) >= XW'(img_h);

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign cmd_push = accept && !ignore;
  assign cmd_col  = in_col;
  assign cmd_pix  = pixel_phase ? pixel_t'(s_tdata) : '0;

  always_comb begin
    cmd_ctl.emit      = emit;
    cmd_ctl.left_mid  = (in_col != '0) && (out_col == '0);
    cmd_ctl.right_new = (in_col != '0);
    cmd_ctl.top_mid   = (out_row == '0);
    cmd_ctl.bot_mid   = out_row_end;
    cmd_ctl.last      = out_row_end && out_col_end;
  end

  // position counters
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (size_we || (cmd_push && emit && cmd_ctl.last)) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (cmd_push) begin
      in_col_next = col_wrap ? '0 : in_col + CW'(1);
      in_row_next = col_wrap ? in_row + RW'(1) : in_row;
      if (emit) begin
        out_col_next = out_col_end ? '0 : out_col + CW'(1);
        out_row_next = out_col_end ? out_row + ORW'(1) : out_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // frame end restarts the position counters
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    cmd_push && cmd_ctl.emit && cmd_ctl.last |=> in_col == '0 && in_row == '0)
    else $error("position not restarted after frame end");

  // input row never runs past the drain range
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(in_row) <= XW'(img_h) + XW'(1))
    else $error("input row beyond drain range");

endmodule

/* sv/sbl_queue.sv */
module sbl_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  import sbl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full      = (count == NW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("command queue underflow");

endmodule

/* sv/sbl_back.sv */
module sbl_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // command queue side
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  sbl_pkg::win_ctl_t            q_ctl,
  input  sbl_pkg::pixel_t              q_pix,
  input  logic                         direction,
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output sbl_pkg::pixel_t              m_tdata,
  output logic                         m_tlast
);
  import sbl_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // one channel of the 3x3 derivative, absolute and saturated
  function automatic logic [CHAN_W-1:0] grad_chan(
    input logic [CHAN_W-1:0] lt, input logic [CHAN_W-1:0] lm, input logic [CHAN_W-1:0] lb,
    input logic [CHAN_W-1:0] mt, input logic [CHAN_W-1:0] mb,
    input logic [CHAN_W-1:0] rt, input logic [CHAN_W-1:0] rm, input logic [CHAN_W-1:0] rb,
    input logic              dir);
    logic [SUM_W-1:0]        p;
    logic [SUM_W-1:0]        n;
    logic signed [SUM_W:0]   d;
    logic [SUM_W:0]          m;
    if (dir) begin
      p = SUM_W'(lb) + (SUM_W'(mb) << 1) + SUM_W'(rb);
      n = SUM_W'(lt) + (SUM_W'(mt) << 1) + SUM_W'(rt);
    end else begin
      p = SUM_W'(rt) + (SUM_W'(rm) << 1) + SUM_W'(rb);
      n = SUM_W'(lt) + (SUM_W'(lm) << 1) + SUM_W'(lb);
    end
    d = $signed({1'b0, p}) - $signed({1'b0, n});
    m = d[SUM_W] ? (~d + (SUM_W+1)'(1)) : d;
    return (|m[SUM_W:CHAN_W]) ? '1 : m[CHAN_W-1:0];
  endfunction

  line_pair_t line_mem [MAX_WIDTH];

  logic       s1_valid;
  logic       s1_adv;
  logic [CW-1:0] s1_col;
  win_ctl_t   s1_ctl;
  pixel_t     s1_pix;
  line_pair_t rd;

  pixel_t col_a [3];   // older window column, rows top to bottom
  pixel_t col_b [3];   // newer window column
  pixel_t col_n [3];   // incoming column
  pixel_t lc [3];
  pixel_t rc [3];
  pixel_t lt, lm, lb, mt, mb, rt, rm, rb;
  pixel_t result;

  assign s1_adv = s1_valid && (!m_tvalid || m_tready);
  assign q_pop  = q_valid && (!s1_valid || s1_adv);

  // line store: read on pop, write back when the request leaves stage one
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd <= line_mem[q_col];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= {rd.middle, s1_pix};
    end
  end

  // stage one request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col <= q_col;
      s1_ctl <= q_ctl;
      s1_pix <= q_pix;
    end
  end

  // column and row selection with edge replication
  always_comb begin
    col_n[0] = rd.upper;
    col_n[1] = rd.middle;
    col_n[2] = s1_pix;
    for (int r = 0; r < 3; r++) begin
      lc[r] = s1_ctl.left_mid  ? col_b[r] : col_a[r];
      rc[r] = s1_ctl.right_new ? col_n[r] : col_b[r];
    end
    lt = s1_ctl.top_mid ? lc[1] : lc[0];
    lm = lc[1];
    lb = s1_ctl.bot_mid ? lc[1] : lc[2];
    mt = s1_ctl.top_mid ? col_b[1] : col_b[0];
    mb = s1_ctl.bot_mid ? col_b[1] : col_b[2];
    rt = s1_ctl.top_mid ? rc[1] : rc[0];
    rm = rc[1];
    rb = s1_ctl.bot_mid ? rc[1] : rc[2];
    result.red   = grad_chan(lt.red, lm.red, lb.red, mt.red, mb.red,
                             rt.red, rm.red, rb.red, direction);
    result.green = grad_chan(lt.green, lm.green, lb.green, mt.green, mb.green,
                             rt.green, rm.green, rb.green, direction);
    result.blue  = grad_chan(lt.blue, lm.blue, lb.blue, mt.blue, mb.blue,
                             rt.blue, rm.blue, rb.blue, direction);
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        col_a[r] <= '0;
        col_b[r] <= '0;
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        col_a[r] <= col_b[r];
        col_b[r] <= col_n[r];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.emit) begin
      m_tdata <= result;
      m_tlast <= s1_ctl.last;
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_ctl.last && s1_ctl.right_new |-> s1_ctl.emit)
    else $error("frame end on a request without result");

  a_left_post_shift: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ctl.left_mid |-> s1_ctl.right_new)
    else $error("left edge replication on a row wrap request");

endmodule
